@@ hw/rtl/ers_pkg.sv @@
// Package for the enclosing rectangle search core.
// Holds sizes, operation and status codes, the stream item layouts and the
// controller-to-datapath command and status structs. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ers_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int COORD_BITS   = 12;
  localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_IDX_W    = $clog2(MAX_SEGMENTS);

  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_QUERY = 2'd1,
    FN_CLEAR = 2'd2
  } ers_func_e;

  typedef enum logic [2:0] {
    STS_LOADED  = 3'd0,
    STS_FULL    = 3'd1,
    STS_CLEARED = 3'd2,
    STS_FOUND   = 3'd3,
    STS_NONE    = 3'd4
  } ers_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ers_state_e;

  // Input tdata layout, lowest field last.
  typedef struct packed {
    logic [2:0]            pad;
    logic [COORD_BITS-1:0] query_y;
    logic [COORD_BITS-1:0] query_x;
    logic [COORD_BITS-1:0] line_to;
    logic [COORD_BITS-1:0] line_from;
    logic [COORD_BITS-1:0] line_pos;
    logic                  line_vertical;
  } ers_in_t;

  // Output tdata layout, lowest field last.
  typedef struct packed {
    logic [COORD_BITS-1:0] rect_bottom;
    logic [COORD_BITS-1:0] rect_right;
    logic [COORD_BITS-1:0] rect_top;
    logic [COORD_BITS-1:0] rect_left;
  } ers_out_t;

  typedef struct packed {
    logic                  vert;
    logic [COORD_BITS-1:0] pos;
    logic [COORD_BITS-1:0] line_from;
    logic [COORD_BITS-1:0] line_to;
  } ers_seg_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_clr;
    logic scan_rd;
    logic out_query;
  } ers_cmd_t;

  typedef struct packed {
    logic [1:0]           func;
    logic                 count_zero;
    logic                 scan_last;
    logic                 out_free;
    logic [SEG_CNT_W-1:0] count;
  } ers_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/enclosing_rectangle_search_core.sv @@
// Top level of the enclosing rectangle search core.
// Joins ers_ctrl and ers_datapath to the request and result streams.
// Depends on ers_pkg, ers_ctrl and ers_datapath.
//
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser: func; tdata: segment or point
// m_axis   out  m_axis_tvalid/m_axis_tready  tuser: status; tdata: rectangle
//
// A load or clear request is executed once the output register is free.
// A query runs ST_START, ST_SCAN, ST_DRAIN and ST_DONE, and skips the scan on an empty table:
// the table memory has one read port, so the scan reads one stored segment per cycle.
// After reset the table is empty and the core is ready at once.
// A request is accepted while a finished result waits in the output register;
// its own result is held back until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module enclosing_rectangle_search_core
  import ers_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0: line_vertical, line_pos, line_from, line_to, query_x,
  // query_y, zero fill.
  input  wire logic [63:0] s_axis_tdata,
  // Fields from bit 0: func.
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Fields from bit 0: rect_left, rect_top, rect_right, rect_bottom.
  output logic [47:0]      m_axis_tdata,
  // Fields from bit 0: status.
  output logic [2:0]       m_axis_tuser
);

  ers_cmd_t cmd;
  ers_sts_t sts;
  ers_out_t out_data;

  ers_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ers_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_func_i    (s_axis_tuser),
    .in_data_i    (ers_in_t'(s_axis_tdata)),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_data),
    .out_status_o (m_axis_tuser)
  );

  assign m_axis_tdata = out_data;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= SEG_CNT_W'(MAX_SEGMENTS))
    else $error("segment count beyond table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == FN_QUERY) |=> !s_axis_tready)
    else $error("new request taken during a query scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STS_FOUND) |-> (m_axis_tdata == '0))
    else $error("rectangle fields set without a found rectangle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_rd |-> !sts.count_zero)
    else $error("scan of an empty table");

endmodule

`default_nettype wire

@@ hw/rtl/ers_ctrl.sv @@
// Controller state machine of the enclosing rectangle search core.
// Sequences request intake, load and clear, the table scan and the result
// hand-off. Depends on ers_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ers_ctrl
  import ers_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic [1:0] in_func_i,
  output logic          in_ready_o,
  input  wire ers_sts_t sts_i,
  output ers_cmd_t      cmd_o
);

  ers_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          case (ers_func_e'(in_func_i))
            FN_QUERY: state_d = ST_START;
            FN_LOAD:  state_d = ST_EXEC;
            FN_CLEAR: state_d = ST_EXEC;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_START: begin
        cmd_o.scan_clr = 1'b1;
        state_d = sts_i.count_zero ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_query = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ers_datapath.sv @@
// Datapath of the enclosing rectangle search core: request registers,
// segment table memory and count, nearest-side accumulators and the output
// register. Driven by ers_ctrl through ers_cmd_t. Depends on ers_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ers_datapath
  import ers_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [1:0]  in_func_i,
  input  wire ers_in_t     in_data_i,
  input  wire ers_cmd_t    cmd_i,
  output ers_sts_t         sts_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output ers_out_t         out_data_o,
  output logic [2:0]       out_status_o
);

  ers_seg_t mem [MAX_SEGMENTS];

  logic [1:0]            func_q;
  ers_in_t               req_q;
  logic [SEG_CNT_W-1:0]  count_q;
  logic [SEG_IDX_W-1:0]  idx_q;
  logic                  rd_vld_q;
  ers_seg_t              rd_q;
  logic                  vl_q, vr_q, vt_q, vb_q;
  logic [COORD_BITS-1:0] bl_q, br_q, bt_q, bb_q;
  logic                  out_valid_q;
  ers_out_t              out_data_q;
  logic [2:0]            out_status_q;
  logic [SEG_CNT_W-1:0]  count_m1;
  logic                  full;
  logic                  inside_v, inside_h;

  assign count_m1 = count_q - SEG_CNT_W'(1);
  assign full     = (count_q >= SEG_CNT_W'(MAX_SEGMENTS));
  assign inside_v = (req_q.query_y > rd_q.line_from) && (req_q.query_y < rd_q.line_to);
  assign inside_h = (req_q.query_x > rd_q.line_from) && (req_q.query_x < rd_q.line_to);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= in_func_i;
      req_q  <= in_data_i;
    end
    if (cmd_i.exec && (func_q == FN_LOAD) && !full) begin
      mem[count_q[SEG_IDX_W-1:0]] <= '{vert:      req_q.line_vertical,
                                       pos:       req_q.line_pos,
                                       line_from: req_q.line_from,
                                       line_to:   req_q.line_to};
    end
    if (cmd_i.scan_rd) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      vl_q     <= 1'b0;
      vr_q     <= 1'b0;
      vt_q     <= 1'b0;
      vb_q     <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.exec) begin
        if (func_q == FN_CLEAR) begin
          count_q <= '0;
        end else if (!full) begin
          count_q <= count_q + SEG_CNT_W'(1);
        end
      end
      if (cmd_i.scan_clr) begin
        idx_q <= '0;
        vl_q  <= 1'b0;
        vr_q  <= 1'b0;
        vt_q  <= 1'b0;
        vb_q  <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          idx_q <= idx_q + SEG_IDX_W'(1);
        end
        if (rd_vld_q && rd_q.vert && inside_v) begin
          if (req_q.query_x > rd_q.pos && (!vl_q || rd_q.pos > bl_q)) begin
            vl_q <= 1'b1;
          end
          if (req_q.query_x < rd_q.pos && (!vr_q || rd_q.pos < br_q)) begin
            vr_q <= 1'b1;
          end
        end
        if (rd_vld_q && !rd_q.vert && inside_h) begin
          if (req_q.query_y > rd_q.pos && (!vt_q || rd_q.pos > bt_q)) begin
            vt_q <= 1'b1;
          end
          if (req_q.query_y < rd_q.pos && (!vb_q || rd_q.pos < bb_q)) begin
            vb_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q && rd_q.vert && inside_v) begin
      if (req_q.query_x > rd_q.pos && (!vl_q || rd_q.pos > bl_q)) begin
        bl_q <= rd_q.pos;
      end
      if (req_q.query_x < rd_q.pos && (!vr_q || rd_q.pos < br_q)) begin
        br_q <= rd_q.pos;
      end
    end
    if (rd_vld_q && !rd_q.vert && inside_h) begin
      if (req_q.query_y > rd_q.pos && (!vt_q || rd_q.pos > bt_q)) begin
        bt_q <= rd_q.pos;
      end
      if (req_q.query_y < rd_q.pos && (!vb_q || rd_q.pos < bb_q)) begin
        bb_q <= rd_q.pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec || cmd_i.out_query) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_data_q <= '0;
      if (func_q == FN_CLEAR) begin
        out_status_q <= STS_CLEARED;
      end else begin
        out_status_q <= full ? STS_FULL : STS_LOADED;
      end
    end else if (cmd_i.out_query) begin
      if (vl_q && vr_q && vt_q && vb_q) begin
        out_status_q <= STS_FOUND;
        out_data_q   <= '{rect_bottom: bb_q, rect_right: br_q,
                          rect_top:    bt_q, rect_left:  bl_q};
      end else begin
        out_status_q <= STS_NONE;
        out_data_q   <= '0;
      end
    end
  end

  assign sts_o.func       = func_q;
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.scan_last  = (idx_q == count_m1[SEG_IDX_W-1:0]);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.count      = count_q;

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for enclosing_rectangle_search_core.
// Drives load, query, clear and unused-code requests on the input stream, predicts each
// result or takes it from the directed table, and checks the output stream. Depends on ers_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import ers_pkg::*;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam logic [11:0] CMAX = 12'hFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic        vert;
    logic [11:0] pos;
    logic [11:0] ext_from;
    logic [11:0] ext_to;
    logic [11:0] qx;
    logic [11:0] qy;
  } seg_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] right;
    logic [11:0] bottom;
  } rect_res_t;

  typedef struct packed {
    seg_req_t  req;
    logic      typed;
    rect_res_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  enclosing_rectangle_search_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  logic        tbl_vert [MAX_SEGMENTS];
  logic [11:0] tbl_pos  [MAX_SEGMENTS];
  logic [11:0] tbl_from [MAX_SEGMENTS];
  logic [11:0] tbl_to   [MAX_SEGMENTS];
  int          tbl_count;

  rect_res_t pending_rects [$];
  dir_row_t  dir_tab [$];

  int n_errors, n_results, n_sent;
  int n_loaded, n_full, n_cleared, n_found, n_none, n_unused;
  int src_idle_pct, sink_stall_pct, sink_hold;
  logic [11:0] last_pos;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("enclosing_rectangle_search_core test failed");
    $finish;
  end

  function automatic void add_row(input dir_row_t row);
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  function automatic bit search_rectangle(input seg_req_t r, output rect_res_t res);
    bit vl, vr, vt, vb;
    logic [11:0] bl, br, bt, bb;
    vl = 0; vr = 0; vt = 0; vb = 0;
    bl = '0; br = '0; bt = '0; bb = '0;
    res = '0;
    if (r.func == FN_LOAD) begin
      if (tbl_count >= MAX_SEGMENTS) begin
        res.status = STS_FULL;
        n_full++;
      end else begin
        tbl_vert[tbl_count] = r.vert;
        tbl_pos[tbl_count]  = r.pos;
        tbl_from[tbl_count] = r.ext_from;
        tbl_to[tbl_count]   = r.ext_to;
        tbl_count++;
        res.status = STS_LOADED;
        n_loaded++;
      end
      return 1;
    end
    if (r.func == FN_CLEAR) begin
      tbl_count = 0;
      res.status = STS_CLEARED;
      n_cleared++;
      return 1;
    end
    if (r.func != FN_QUERY) begin
      n_unused++;
      return 0;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_vert[i]) begin
        if (r.qy > tbl_from[i] && r.qy < tbl_to[i]) begin
          if (r.qx > tbl_pos[i] && (!vl || tbl_pos[i] > bl)) begin
            vl = 1; bl = tbl_pos[i];
          end
          if (r.qx < tbl_pos[i] && (!vr || tbl_pos[i] < br)) begin
            vr = 1; br = tbl_pos[i];
          end
        end
      end else if (r.qx > tbl_from[i] && r.qx < tbl_to[i]) begin
        if (r.qy > tbl_pos[i] && (!vt || tbl_pos[i] > bt)) begin
          vt = 1; bt = tbl_pos[i];
        end
        if (r.qy < tbl_pos[i] && (!vb || tbl_pos[i] < bb)) begin
          vb = 1; bb = tbl_pos[i];
        end
      end
    end
    if (vl && vr && vt && vb) begin
      res = '{STS_FOUND, bl, bt, br, bb};
      n_found++;
    end else begin
      res.status = STS_NONE;
      n_none++;
    end
    return 1;
  endfunction

  task automatic put_request(input seg_req_t r, input logic typed, input rect_res_t typed_res);
    int gap;
    ers_in_t pl;
    rect_res_t res;
    gap = 0;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pl = '{pad: 3'b0, query_y: r.qy, query_x: r.qx, line_to: r.ext_to,
           line_from: r.ext_from, line_pos: r.pos, line_vertical: r.vert};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 64'(pl);
    s_axis_tuser  <= r.func;
    do @(posedge clk_i); while (!s_axis_tready);
    if (search_rectangle(r, res))
      pending_rects.insert(pending_rects.size(), typed ? typed_res : res);
    if (r.func != FN_UNUSED) n_sent++;
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_rects.size() != 0);
  endtask

  function automatic seg_req_t make_segment();
    seg_req_t r;
    r = '0;
    r.func = FN_LOAD;
    r.vert = 1'($urandom_range(1));
    case ($urandom_range(19))
      0:       r.pos = 12'd0;
      1:       r.pos = CMAX;
      2, 3:    r.pos = last_pos;
      default: r.pos = 12'($urandom_range(4095));
    endcase
    if ($urandom_range(9) == 0) begin
      r.ext_from = 12'($urandom_range(4095));
      r.ext_to   = 12'($urandom_range(4095));
    end else begin
      r.ext_from = 12'($urandom_range(1500));
      r.ext_to   = 12'($urandom_range(4095, 2500));
    end
    r.qx = 12'($urandom_range(4095));
    r.qy = 12'($urandom_range(4095));
    last_pos = r.pos;
    return r;
  endfunction

  function automatic seg_req_t make_query();
    seg_req_t r;
    int k, idx;
    r = '0;
    r.func = FN_QUERY;
    r.vert = 1'($urandom_range(1));
    r.pos = 12'($urandom_range(4095));
    r.ext_from = 12'($urandom_range(4095));
    r.ext_to = 12'($urandom_range(4095));
    k = $urandom_range(9);
    if (k < 6) begin
      r.qx = 12'($urandom_range(3000, 1000));
      r.qy = 12'($urandom_range(3000, 1000));
    end else begin
      r.qx = 12'($urandom_range(4095));
      r.qy = 12'($urandom_range(4095));
    end
    if (k >= 6 && k < 8 && tbl_count > 0) begin
      idx = $urandom_range(tbl_count - 1);
      if (tbl_vert[idx]) r.qx = tbl_pos[idx];
      else r.qy = tbl_pos[idx];
      if (k == 7) begin
        if (tbl_vert[idx]) r.qy = tbl_from[idx];
        else r.qx = tbl_to[idx];
      end
    end
    return r;
  endfunction

  // Receiver side: checks every accepted result and applies stalls and hold-offs.
  initial begin
    rect_res_t got, want;
    ers_out_t o;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        o = m_axis_tdata;
        got = '{m_axis_tuser, o.rect_left, o.rect_top, o.rect_right, o.rect_bottom};
        n_results++;
        if (pending_rects.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: unexpected result status %0d rect %0d %0d %0d %0d", $realtime,
                     got.status, got.left, got.top, got.right, got.bottom);
        end else begin
          want = pending_rects.pop_front();
          if (got.status !== want.status || got.left !== want.left ||
              got.top !== want.top || got.right !== want.right ||
              got.bottom !== want.bottom) begin
            n_errors++;
            if (n_errors <= 10)
              $display({"%0t: mismatch exp status %0d rect %0d %0d %0d %0d,",
                        " got %0d rect %0d %0d %0d %0d"},
                       $realtime, want.status, want.left, want.top, want.right,
                       want.bottom, got.status, got.left, got.top, got.right,
                       got.bottom);
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct);
      end
    end
  end

  initial begin
    seg_req_t r;
    logic [63:0] rnd;
    int ep, nseg, nq, k;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    n_errors = 0; n_results = 0; n_sent = 0;
    n_loaded = 0; n_full = 0; n_cleared = 0; n_found = 0; n_none = 0; n_unused = 0;
    src_idle_pct = 0; sink_stall_pct = 0; sink_hold = 0;
    tbl_count = 0;
    last_pos = '0;

    add_row('{'{FN_QUERY, 1'b0, 12'd0, 12'd0, 12'd0, 12'd2048, 12'd2048},
              1'b1, '{STS_NONE, 12'd0, 12'd0, 12'd0, 12'd0}});
    add_row('{'{FN_LOAD, 1'b1, 12'd100, 12'd0, CMAX, 12'd0, 12'd0},
              1'b1, '{STS_LOADED, 12'd0, 12'd0, 12'd0, 12'd0}});
    add_row('{'{FN_LOAD, 1'b1, 12'd300, 12'd0, CMAX, 12'd0, 12'd0},
              1'b1, '{STS_LOADED, 12'd0, 12'd0, 12'd0, 12'd0}});
    add_row('{'{FN_LOAD, 1'b0, 12'd50, 12'd0, CMAX, 12'd0, 12'd0},
              1'b1, '{STS_LOADED, 12'd0, 12'd0, 12'd0, 12'd0}});
    add_row('{'{FN_LOAD, 1'b0, 12'd400, 12'd0, CMAX, 12'd0, 12'd0},
              1'b1, '{STS_LOADED, 12'd0, 12'd0, 12'd0, 12'd0}});
    add_row('{'{FN_QUERY, 1'b0, 12'd0, 12'd0, 12'd0, 12'd200, 12'd200},
              1'b1, '{STS_FOUND, 12'd100, 12'd50, 12'd300, 12'd400}});
    add_row('{'{FN_LOAD, 1'b1, 12'd0, 12'd0, CMAX, 12'd0, 12'd0}, 1'b0, '0});
    add_row('{'{FN_LOAD, 1'b1, CMAX, 12'd0, CMAX, 12'd0, 12'd0}, 1'b0, '0});
    add_row('{'{FN_LOAD, 1'b0, 12'd0, 12'd0, CMAX, 12'd0, 12'd0}, 1'b0, '0});
    add_row('{'{FN_LOAD, 1'b0, CMAX, 12'd0, CMAX, 12'd0, 12'd0}, 1'b0, '0});
    add_row('{'{FN_QUERY, 1'b0, 12'd0, 12'd0, 12'd0, CMAX, CMAX}, 1'b0, '0});
    add_row('{'{FN_QUERY, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0}, 1'b0, '0});
    add_row('{'{FN_QUERY, 1'b0, 12'd0, 12'd0, 12'd0, 12'd200, 12'd200}, 1'b0, '0});
    add_row('{'{FN_LOAD, 1'b1, 12'd150, 12'd3000, 12'd1000, 12'd0, 12'd0}, 1'b0, '0});
    add_row('{'{FN_LOAD, 1'b1, 12'd250, 12'd2000, 12'd2000, 12'd0, 12'd0}, 1'b0, '0});
    add_row('{'{FN_QUERY, 1'b0, 12'd0, 12'd0, 12'd0, 12'd200, 12'd2000}, 1'b0, '0});
    add_row('{'{FN_LOAD, 1'b1, 12'd300, 12'd0, CMAX, 12'd0, 12'd0}, 1'b0, '0});
    add_row('{'{FN_QUERY, 1'b0, 12'd0, 12'd0, 12'd0, 12'd100, 12'd200}, 1'b0, '0});
    add_row('{'{FN_QUERY, 1'b0, 12'd0, 12'd0, 12'd0, 12'd1, 12'd1}, 1'b0, '0});
    add_row('{'{FN_UNUSED, 1'b1, CMAX, CMAX, CMAX, CMAX, CMAX}, 1'b0, '0});
    add_row('{'{FN_CLEAR, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
              1'b1, '{STS_CLEARED, 12'd0, 12'd0, 12'd0, 12'd0}});
    add_row('{'{FN_QUERY, 1'b0, 12'd0, 12'd0, 12'd0, 12'd200, 12'd200},
              1'b1, '{STS_NONE, 12'd0, 12'd0, 12'd0, 12'd0}});
    add_row('{'{FN_LOAD, 1'b1, CMAX, CMAX, CMAX, CMAX, CMAX},
              1'b1, '{STS_LOADED, 12'd0, 12'd0, 12'd0, 12'd0}});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) put_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
    wait_results_done();
    n_sent = 0;

    ep = 0;
    while (n_sent < 750) begin
      case ((n_sent / 80) % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
        default: begin src_idle_pct = 8; sink_stall_pct = 8; end
      endcase
      if (ep == 2 || ep == 17) sink_hold = 300;
      k = $urandom_range(99);
      if (k < 85) begin
        if ($urandom_range(9) != 0) begin
          r = '0;
          r.func = FN_CLEAR;
          r.pos = 12'($urandom_range(4095));
          r.qx = 12'($urandom_range(4095));
          put_request(r, 1'b0, '0);
        end
        k = $urandom_range(9);
        nseg = (k < 7) ? $urandom_range(16, 4) :
               (k < 9) ? $urandom_range(32, 17) : $urandom_range(40, 33);
        repeat (nseg) put_request(make_segment(), 1'b0, '0);
        nq = $urandom_range(8, 2);
        repeat (nq) begin
          if ($urandom_range(5) == 0) put_request(make_segment(), 1'b0, '0);
          put_request(make_query(), 1'b0, '0);
        end
      end else begin
        repeat (10) begin
          rnd = {$urandom(), $urandom()};
          r = rnd[62:0];
          put_request(r, 1'b0, '0);
        end
      end
      if ($urandom_range(3) == 0) wait_results_done();
      ep++;
    end

    wait_results_done();
    repeat (60) @(posedge clk_i);
    if (pending_rects.size() != 0) begin
      $display("%0d expected results never arrived", pending_rects.size());
      n_errors += pending_rects.size();
    end
    $display({"Covered %0d requests in %0d sequences: %0d loads,",
              " %0d dropped on a full table, %0d clears."},
             n_sent, ep, n_loaded, n_full, n_cleared);
    $display({"Queries gave %0d rectangles and %0d misses; %0d unused codes ignored;",
              " %0d results checked."},
             n_found, n_none, n_unused, n_results);
    if (n_errors == 0) begin
      $display("enclosing_rectangle_search_core test passed");
    end else begin
      $display("enclosing_rectangle_search_core test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ers_pkg.sv
hw/rtl/ers_ctrl.sv
hw/rtl/ers_datapath.sv
hw/rtl/enclosing_rectangle_search_core.sv
tb/tb.sv
